/* src/gf2sa_pkg.sv */
package gf2sa_pkg;

    localparam int COL_W = 64;
    localparam int NQ_W  = 7;
    localparam int NW_W  = 3;

    localparam logic [2:0] K_WRITE_COL  = 3'd0;
    localparam logic [2:0] K_WRITE_FLAG = 3'd1;
    localparam logic [2:0] K_APPEND     = 3'd2;
    localparam logic [2:0] K_CLEAR      = 3'd3;
    localparam logic [2:0] K_COMPUTE    = 3'd4;

    localparam logic [1:0] CFG_QUBITS = 2'd0;
    localparam logic [1:0] CFG_WORDS  = 2'd1;

    typedef struct packed {
        logic load;
        logic clr_acc;
        logic q_acc;
        logic xf_rd;
        logic xs_rd;
        logic pf_wr;
        logic ps_rd;
        logic ps_wr;
        logic or_acc;
        logic emit;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic out_free;
    } t_stat;

endpackage

/* src/gf2sa_ram.sv */
module gf2sa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/gf2sa_ctrl.sv */
module gf2sa_ctrl
    import gf2sa_pkg::*;
#(
    parameter int NUM_QUBITS = 64,
    parameter int NUM_WORDS  = 4,
    parameter int MAX_EDGES  = 256,
    localparam int QW  = NUM_QUBITS > 1 ? $clog2(NUM_QUBITS) : 1,
    localparam int WW  = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1,
    localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1,
    localparam int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_kind,
    output logic            o_stall,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [NQ_W-1:0] i_cfg_data,
    input  logic [ECW-1:0]  i_ecount,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic [QW-1:0]   o_j,
    output logic [EW-1:0]   o_e,
    output logic [WW-1:0]   o_w,
    output logic [NQ_W-1:0] o_n
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WST  = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_QACC = 4'd3;
    localparam logic [3:0] S_EST  = 4'd4;
    localparam logic [3:0] S_ERD  = 4'd5;
    localparam logic [3:0] S_EXF  = 4'd6;
    localparam logic [3:0] S_EXS  = 4'd7;
    localparam logic [3:0] S_EPF  = 4'd8;
    localparam logic [3:0] S_EPSR = 4'd9;
    localparam logic [3:0] S_EPSW = 4'd10;
    localparam logic [3:0] S_OST  = 4'd11;
    localparam logic [3:0] S_ORD  = 4'd12;
    localparam logic [3:0] S_OACC = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    localparam int WCW = $clog2(NUM_WORDS + 1);

    logic [3:0]      r_state, n_state;
    logic [QW-1:0]   r_j, n_j;
    logic [EW-1:0]   r_e, n_e;
    logic [WW-1:0]   r_w, n_w;
    logic [NQ_W-1:0] r_cfg_q;
    logic [NW_W-1:0] r_cfg_w;
    logic [NQ_W-1:0] n_q;
    logic [WCW-1:0]  n_words;
    logic            j_end, e_end, w_end;

    always_comb begin
        n_q = (r_cfg_q > NQ_W'(NUM_QUBITS)) ? NQ_W'(NUM_QUBITS) : r_cfg_q;
        if (r_cfg_w == '0) begin
            n_words = WCW'(1);
        end else if (32'(r_cfg_w) > NUM_WORDS) begin
            n_words = WCW'(NUM_WORDS);
        end else begin
            n_words = WCW'(r_cfg_w);
        end
        j_end = (NQ_W'(r_j) + NQ_W'(1)) == n_q;
        e_end = (ECW'(r_e) + ECW'(1)) == i_ecount;
        w_end = (WCW'(r_w) + WCW'(1)) == n_words;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_j = r_j;
    assign o_e = r_e;
    assign o_w = r_w;
    assign o_n = n_q;

    always_comb begin
        n_state = r_state;
        n_j = r_j;
        n_e = r_e;
        n_w = r_w;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_kind == K_COMPUTE) begin
                        n_w = '0;
                        n_state = S_WST;
                    end
                end
            end
            S_WST: begin
                o_cmd.clr_acc = 1'b1;
                n_j = '0;
                n_state = (n_q == '0) ? S_EST : S_QRD;
            end
            S_QRD: begin
                n_state = S_QACC;
            end
            S_QACC: begin
                o_cmd.q_acc = 1'b1;
                n_j = r_j + QW'(1);
                n_state = j_end ? S_EST : S_QRD;
            end
            S_EST: begin
                n_e = '0;
                n_state = (i_ecount == '0) ? S_OST : S_ERD;
            end
            S_ERD: begin
                n_state = S_EXF;
            end
            S_EXF: begin
                if (i_stat.skip) begin
                    n_e = r_e + EW'(1);
                    n_state = e_end ? S_OST : S_ERD;
                end else begin
                    o_cmd.xf_rd = 1'b1;
                    n_state = S_EXS;
                end
            end
            S_EXS: begin
                o_cmd.xs_rd = 1'b1;
                n_state = S_EPF;
            end
            S_EPF: begin
                o_cmd.pf_wr = 1'b1;
                n_state = S_EPSR;
            end
            S_EPSR: begin
                o_cmd.ps_rd = 1'b1;
                n_state = S_EPSW;
            end
            S_EPSW: begin
                o_cmd.ps_wr = 1'b1;
                n_e = r_e + EW'(1);
                n_state = e_end ? S_OST : S_ERD;
            end
            S_OST: begin
                n_j = '0;
                n_state = (n_q == '0) ? S_EMIT : S_ORD;
            end
            S_ORD: begin
                n_state = S_OACC;
            end
            S_OACC: begin
                o_cmd.or_acc = 1'b1;
                n_j = r_j + QW'(1);
                n_state = j_end ? S_EMIT : S_ORD;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_end;
                    if (w_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_w = r_w + WW'(1);
                        n_state = S_WST;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j <= '0;
            r_e <= '0;
            r_w <= '0;
            r_cfg_q <= NQ_W'(64);
            r_cfg_w <= NW_W'(1);
        end else begin
            r_state <= n_state;
            r_j <= n_j;
            r_e <= n_e;
            r_w <= n_w;
            if (i_cfg_valid && i_cfg_index == CFG_QUBITS) begin
                r_cfg_q <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_WORDS) begin
                r_cfg_w <= i_cfg_data[NW_W-1:0];
            end
        end
    end
endmodule

/* src/gf2sa_dp.sv */
module gf2sa_dp
    import gf2sa_pkg::*;
#(
    parameter int NUM_QUBITS = 64,
    parameter int NUM_WORDS  = 4,
    parameter int MAX_EDGES  = 256,
    localparam int QW  = NUM_QUBITS > 1 ? $clog2(NUM_QUBITS) : 1,
    localparam int WW  = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1,
    localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1,
    localparam int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [QW-1:0]    i_j,
    input  logic [EW-1:0]    i_e,
    input  logic [WW-1:0]    i_w,
    input  logic [NQ_W-1:0]  i_n,
    output t_stat            o_stat,
    output logic [ECW-1:0]   o_ecount,
    input  logic [2:0]       i_kind,
    input  logic [5:0]       i_qubit,
    input  logic [5:0]       i_partner,
    input  logic [1:0]       i_word_sel,
    input  logic [COL_W-1:0] i_x_word,
    input  logic [COL_W-1:0] i_z_word,
    input  logic             i_prefix_x_bit,
    input  logic             i_prefix_z_bit,
    input  logic             i_a_bit,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [COL_W-1:0] o_sign_word,
    output logic [COL_W-1:0] o_active_word,
    output logic [1:0]       o_word_out,
    output logic             o_last,
    output logic             o_edge_overflow
);
    localparam int CD  = NUM_QUBITS * NUM_WORDS;
    localparam int CAW = CD > 1 ? $clog2(CD) : 1;

    logic [NUM_QUBITS-1:0] r_px, r_pz, r_a;
    logic [ECW-1:0]        r_ecount;
    logic                  r_ovf;
    logic [COL_W-1:0]      r_sign, r_ones, r_twos, r_active, r_xf;

    logic             col_we, edge_we, q_ok, p_ok;
    logic [CAW-1:0]   col_waddr, col_raddr;
    logic [COL_W-1:0] x_rdata, z_rdata, pat_rdata, pat_wdata;
    logic [11:0]      edge_rdata;
    logic [5:0]       ef, es;
    logic             pat_we;
    logic [QW-1:0]    pat_waddr, pat_raddr;
    logic [5:0]       sel_q;

    assign q_ok = 32'(i_qubit) < NUM_QUBITS;
    assign p_ok = 32'(i_partner) < NUM_QUBITS;
    assign col_we = i_cmd.load && i_kind == K_WRITE_COL && q_ok
        && 32'(i_word_sel) < NUM_WORDS;
    assign edge_we = i_cmd.load && i_kind == K_APPEND && q_ok && p_ok
        && 32'(r_ecount) < MAX_EDGES;
    assign col_waddr = CAW'(i_qubit) * CAW'(NUM_WORDS) + CAW'(i_word_sel);
    assign ef = edge_rdata[11:6];
    assign es = edge_rdata[5:0];

    always_comb begin
        if (i_cmd.xf_rd) begin
            sel_q = ef;
        end else if (i_cmd.xs_rd) begin
            sel_q = es;
        end else begin
            sel_q = 6'(i_j);
        end
        col_raddr = CAW'(sel_q) * CAW'(NUM_WORDS) + CAW'(i_w);
        pat_raddr = i_cmd.xs_rd ? QW'(ef) : (i_cmd.ps_rd ? QW'(es) : i_j);
        pat_we = i_cmd.q_acc || i_cmd.pf_wr || i_cmd.ps_wr;
        if (i_cmd.q_acc) begin
            pat_waddr = i_j;
            pat_wdata = r_a[i_j] ? x_rdata : '0;
        end else if (i_cmd.pf_wr) begin
            pat_waddr = QW'(ef);
            pat_wdata = pat_rdata ^ x_rdata;
        end else begin
            pat_waddr = QW'(es);
            pat_wdata = pat_rdata ^ r_xf;
        end
    end

    assign o_stat.skip = (NQ_W'(ef) >= i_n) || (NQ_W'(es) >= i_n);
    assign o_stat.out_free = !o_valid || !i_stall;
    assign o_ecount = r_ecount;

    gf2sa_ram #(.WIDTH(COL_W), .DEPTH(CD)) u_xram (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(i_x_word),
        .i_raddr(col_raddr), .o_rdata(x_rdata)
    );
    gf2sa_ram #(.WIDTH(COL_W), .DEPTH(CD)) u_zram (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(col_waddr), .i_wdata(i_z_word),
        .i_raddr(col_raddr), .o_rdata(z_rdata)
    );
    gf2sa_ram #(.WIDTH(12), .DEPTH(MAX_EDGES)) u_eram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(r_ecount[EW-1:0]),
        .i_wdata({i_qubit, i_partner}), .i_raddr(i_e), .o_rdata(edge_rdata)
    );
    gf2sa_ram #(.WIDTH(COL_W), .DEPTH(NUM_QUBITS)) u_pram (
        .i_clk(i_clk), .i_we(pat_we), .i_waddr(pat_waddr), .i_wdata(pat_wdata),
        .i_raddr(pat_raddr), .o_rdata(pat_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_pz <= '0;
            r_a <= '0;
            r_ecount <= '0;
            r_ovf <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_kind == K_WRITE_FLAG && q_ok) begin
                r_px[QW'(i_qubit)] <= i_prefix_x_bit;
                r_pz[QW'(i_qubit)] <= i_prefix_z_bit;
                r_a[QW'(i_qubit)] <= i_a_bit;
            end
            if (i_cmd.load && i_kind == K_APPEND && q_ok && p_ok) begin
                if (edge_we) begin
                    r_ecount <= r_ecount + ECW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load && i_kind == K_CLEAR) begin
                r_px <= '0;
                r_pz <= '0;
                r_a <= '0;
                r_ecount <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_sign <= '0;
            r_ones <= '0;
            r_twos <= '0;
            r_active <= '0;
        end
        if (i_cmd.q_acc) begin
            r_sign <= r_sign ^ (r_px[i_j] ? z_rdata : '0) ^ (r_pz[i_j] ? x_rdata : '0);
            if (r_a[i_j]) begin
                r_twos <= r_twos ^ (r_ones & x_rdata);
                r_ones <= r_ones ^ x_rdata;
            end
        end
        if (i_cmd.xs_rd) begin
            r_xf <= x_rdata;
        end
        if (i_cmd.pf_wr) begin
            r_sign <= r_sign ^ (r_xf & x_rdata);
        end
        if (i_cmd.or_acc) begin
            r_active <= r_active | pat_rdata;
        end
        if (i_cmd.emit) begin
            o_sign_word <= r_sign ^ r_twos;
            o_active_word <= r_active;
            o_word_out <= 2'(i_w);
            o_last <= i_cmd.last;
            o_edge_overflow <= r_ovf;
        end
    end
endmodule

/* src/gf2_sign_and_active_planes.sv */
// Bit-sliced GF(2) sign and active-plane kernel. Load items (column word, qubit flags,
// edge append, clear) are taken while idle and leave the kernel idle. A compute item
// gives one result beat per generator word; each word runs a qubit pass, an edge pass
// (skipped edges are only read; the rest do a read-modify-write of the pattern memory),
// an OR pass over the qubits and an emit, split into steps by the single read port of
// the X-column memory. No item is accepted while a compute runs; the last result beat
// may still wait in the output register while the next item is taken.
module gf2_sign_and_active_planes
    import gf2sa_pkg::*;
#(
    parameter int NUM_QUBITS = 64,
    parameter int NUM_WORDS  = 4,
    parameter int MAX_EDGES  = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [2:0]       i_kind,
    input  logic [5:0]       i_qubit,
    input  logic [5:0]       i_partner,
    input  logic [1:0]       i_word_sel,
    input  logic [COL_W-1:0] i_x_word,
    input  logic [COL_W-1:0] i_z_word,
    input  logic             i_prefix_x_bit,
    input  logic             i_prefix_z_bit,
    input  logic             i_a_bit,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [COL_W-1:0] o_sign_word,
    output logic [COL_W-1:0] o_active_word,
    output logic [1:0]       o_word_out,
    output logic             o_last,
    output logic             o_edge_overflow,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [NQ_W-1:0]  i_cfg_data
);
    localparam int QW  = NUM_QUBITS > 1 ? $clog2(NUM_QUBITS) : 1;
    localparam int WW  = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    t_cmd            cmd;
    t_stat           stat;
    logic [QW-1:0]   j;
    logic [EW-1:0]   e;
    logic [WW-1:0]   w;
    logic [NQ_W-1:0] n;
    logic [ECW-1:0]  ecount;

    assign o_cfg_ready = 1'b1;

    gf2sa_ctrl #(.NUM_QUBITS(NUM_QUBITS), .NUM_WORDS(NUM_WORDS), .MAX_EDGES(MAX_EDGES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_kind(i_kind),
        .o_stall(o_stall), .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_ecount(ecount), .i_stat(stat), .o_cmd(cmd),
        .o_j(j), .o_e(e), .o_w(w), .o_n(n)
    );

    gf2sa_dp #(.NUM_QUBITS(NUM_QUBITS), .NUM_WORDS(NUM_WORDS), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_j(j), .i_e(e), .i_w(w),
        .i_n(n), .o_stat(stat), .o_ecount(ecount), .i_kind(i_kind),
        .i_qubit(i_qubit), .i_partner(i_partner), .i_word_sel(i_word_sel),
        .i_x_word(i_x_word), .i_z_word(i_z_word), .i_prefix_x_bit(i_prefix_x_bit),
        .i_prefix_z_bit(i_prefix_z_bit), .i_a_bit(i_a_bit), .o_valid(o_valid),
        .i_stall(i_stall), .o_sign_word(o_sign_word), .o_active_word(o_active_word),
        .o_word_out(o_word_out), .o_last(o_last), .o_edge_overflow(o_edge_overflow)
    );

`ifndef NO_ASSERTIONS
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == K_COMPUTE |=> o_stall)
        else $error("compute did not start");
    a_ecount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(ecount) <= MAX_EDGES)
        else $error("edge count beyond capacity");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result overwritten while stalled");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && cmd.last |=> !o_stall)
        else $error("no return to idle after last word");
`endif
endmodule
